>>> rtl/spm_pkg.sv
// spm_pkg: shared types and constants for the stereo paint mixer
// used by spm_ctrl, spm_datapath and stereo_paint_mixer_unit; no dependencies
package spm_pkg;

  localparam int PAINT_DEPTH = 2048;
  localparam int IDX_W       = $clog2(PAINT_DEPTH);
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_MIX8  = 2'd1,
    CMD_MIX16 = 2'd2,
    CMD_EMIT  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASTER_Q8   = 3'd0,
    REG_GAIN16      = 3'd1,
    REG_OUTPUT_8BIT = 3'd2,
    REG_STEREO_OUT  = 3'd3,
    REG_RING_LOG2   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL1,
    S_MUL2,
    S_WRITE,
    S_EMIT_L,
    S_EMIT_R
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic mul1_en;
    logic mul2_en;
    logic wr_en;
    logic emit_load;
    logic emit_right;
    logic emit_last;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic stereo;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/stereo_paint_mixer_unit.sv
// stereo_paint_mixer_unit: top level of the stereo paint mixer
// depends on spm_pkg, spm_ctrl and spm_datapath
//
//  channel  handshake                 payload
//  in       in_valid / in_stall       command, buffer_index, sample, volumes, loads, frame
//  out      out_valid / out_stall     out_sample, out_address, last
//  cfg      cfg_we                    cfg_index, cfg_data
//
// load: fetch, write; mix: fetch, two multiplier stages, write (store read-modify-write);
// emit: fetch, left, then right if stereo; one item at a time through the state machine
// a held output item adds its stall cycles to the emit that follows it
// rst is synchronous and restores the register defaults; the store is not cleared
module stereo_paint_mixer_unit
  import spm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [10:0]          buffer_index,
  input  logic signed [15:0]   sample,
  input  logic [7:0]           left_volume,
  input  logic [7:0]           right_volume,
  input  logic signed [31:0]   load_left,
  input  logic signed [31:0]   load_right,
  input  logic [30:0]          frame_position,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_sample,
  output logic [15:0]          out_address,
  output logic                 last
);

  dp_cmd_t    ctrl;
  dp_status_t status;

  spm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctrl     (ctrl)
  );

  spm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command        (command),
    .buffer_index   (buffer_index),
    .sample         (sample),
    .left_volume    (left_volume),
    .right_volume   (right_volume),
    .load_left      (load_left),
    .load_right     (load_right),
    .frame_position (frame_position),
    .ctrl           (ctrl),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_address    (out_address),
    .last           (last)
  );

endmodule

>>> rtl/spm_ctrl.sv
// spm_ctrl: sequencing state machine for the stereo paint mixer
// depends on spm_pkg; drives spm_datapath through dp_cmd_t
module spm_ctrl
  import spm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    ctrl
);

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_FETCH;
      end
      S_FETCH: begin
        unique case (status.cmd)
          CMD_LOAD:  state_next = S_WRITE;
          CMD_MIX8:  state_next = S_MUL1;
          CMD_MIX16: state_next = S_MUL1;
          CMD_EMIT:  state_next = S_EMIT_L;
          default:   state_next = S_IDLE;
        endcase
      end
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      S_EMIT_L: begin
        if (status.out_free) state_next = status.stereo ? S_EMIT_R : S_IDLE;
      end
      S_EMIT_R: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.capture = accept;
    unique case (state)
      S_IDLE:  ;
      S_FETCH: ctrl.rd_en = 1'b1;
      S_MUL1:  ctrl.mul1_en = 1'b1;
      S_MUL2:  ctrl.mul2_en = 1'b1;
      S_WRITE: ctrl.wr_en = 1'b1;
      S_EMIT_L: begin
        ctrl.emit_load = status.out_free;
        ctrl.emit_last = !status.stereo;
      end
      S_EMIT_R: begin
        ctrl.emit_load  = status.out_free;
        ctrl.emit_right = 1'b1;
        ctrl.emit_last  = 1'b1;
      end
      default: ;
    endcase
  end

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("accepted item did not make the block busy");

  a_no_write_and_emit: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.wr_en && ctrl.emit_load))
    else $error("store write and emit in the same cycle");

  a_right_follows_left: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit_load && ctrl.emit_right) |-> $past(state == S_EMIT_L || state == S_EMIT_R))
    else $error("right lane emitted without left lane");

endmodule

>>> rtl/spm_datapath.sv
// spm_datapath: paint store, config registers, multipliers and output register
// depends on spm_pkg; commanded by spm_ctrl
module spm_datapath
  import spm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [1:0]           command,
  input  logic [10:0]          buffer_index,
  input  logic signed [15:0]   sample,
  input  logic [7:0]           left_volume,
  input  logic [7:0]           right_volume,
  input  logic signed [31:0]   load_left,
  input  logic signed [31:0]   load_right,
  input  logic [30:0]          frame_position,
  input  dp_cmd_t              ctrl,
  output dp_status_t           status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_sample,
  output logic [15:0]          out_address,
  output logic                 last
);

  // config registers
  logic [8:0] master_q8;
  logic [7:0] gain16;
  logic       output_8bit;
  logic       stereo_out;
  logic [4:0] ring_size_log2;

  // captured item
  cmd_t              cmd_q;
  logic [IDX_W-1:0]  addr_q;
  logic              ok_q;
  logic signed [15:0] sample_q;
  logic [7:0]        lvol_q, rvol_q;
  logic [31:0]       load_l_q, load_r_q;
  logic [30:0]       frame_q;

  // paint store
  logic [31:0] mem_l [PAINT_DEPTH];
  logic [31:0] mem_r [PAINT_DEPTH];
  logic [31:0] rd_l, rd_r;

  // multiplier pipeline
  logic signed [15:0] m1_a;
  logic signed [8:0]  m1_lb, m1_rb;
  logic signed [24:0] p1_l, p1_r;
  logic signed [24:0] m2_la, m2_ra;
  logic signed [17:0] m2_lb, m2_rb;
  logic signed [42:0] prod_l, prod_r;
  logic [31:0]        add_l, add_r;
  logic [31:0]        wr_l, wr_r;

  // emit
  logic [31:0] emit_acc;
  logic [15:0] emit_base;
  logic [16:0] mask_full;
  logic [4:0]  ring_lg;

  function automatic logic [15:0] emit_value(input logic [31:0] acc, input logic out8);
    logic signed [23:0] sh;
    logic [15:0]        v;
    sh = signed'(acc[31:8]);
    if (sh > 24'sd32767) begin
      v = 16'h7FFF;
    end else if (sh < -24'sd32768) begin
      v = 16'h8000;
    end else begin
      v = sh[15:0];
    end
    if (out8) begin
      v = {8'h00, ~v[15], v[14:8]};
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      master_q8      <= 9'd256;
      gain16         <= 8'd255;
      output_8bit    <= 1'b0;
      stereo_out     <= 1'b1;
      ring_size_log2 <= 5'd14;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MASTER_Q8:   master_q8      <= cfg_data[8:0];
        REG_GAIN16:      gain16         <= cfg_data[7:0];
        REG_OUTPUT_8BIT: output_8bit    <= cfg_data[0];
        REG_STEREO_OUT:  stereo_out     <= cfg_data[0];
        REG_RING_LOG2:   ring_size_log2 <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q    <= cmd_t'(command);
      addr_q   <= IDX_W'(buffer_index);
      ok_q     <= (32'(buffer_index) < 32'(PAINT_DEPTH));
      sample_q <= sample;
      lvol_q   <= left_volume;
      rvol_q   <= right_volume;
      load_l_q <= load_left;
      load_r_q <= load_right;
      frame_q  <= frame_position;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_l <= mem_l[addr_q];
      rd_r <= mem_r[addr_q];
    end
    if (ctrl.wr_en && ok_q) begin
      mem_l[addr_q] <= wr_l;
      mem_r[addr_q] <= wr_r;
    end
  end

  assign wr_l = (cmd_q == CMD_LOAD) ? load_l_q : rd_l + add_l;
  assign wr_r = (cmd_q == CMD_LOAD) ? load_r_q : rd_r + add_r;

  // first product: (vol >> 3) * master for mix8, sample * vol for mix16
  always_comb begin
    if (cmd_q == CMD_MIX8) begin
      m1_a  = signed'({7'b0, master_q8});
      m1_lb = signed'({4'b0, lvol_q[7:3]});
      m1_rb = signed'({4'b0, rvol_q[7:3]});
    end else begin
      m1_a  = sample_q;
      m1_lb = signed'({1'b0, lvol_q});
      m1_rb = signed'({1'b0, rvol_q});
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul1_en) begin
      p1_l <= m1_a * m1_lb;
      p1_r <= m1_a * m1_rb;
    end
  end

  // second product: byte * scale * 8 for mix8, first product * gain for mix16
  always_comb begin
    if (cmd_q == CMD_MIX8) begin
      m2_la = {{17{sample_q[7]}}, sample_q[7:0]};
      m2_ra = {{17{sample_q[7]}}, sample_q[7:0]};
      m2_lb = signed'({1'b0, p1_l[13:0], 3'b000});
      m2_rb = signed'({1'b0, p1_r[13:0], 3'b000});
    end else begin
      m2_la = p1_l;
      m2_ra = p1_r;
      m2_lb = signed'({10'b0, gain16});
      m2_rb = signed'({10'b0, gain16});
    end
  end

  assign prod_l = m2_la * m2_lb;
  assign prod_r = m2_ra * m2_rb;

  always_ff @(posedge clk) begin
    if (ctrl.mul2_en) begin
      add_l <= (cmd_q == CMD_MIX8) ? prod_l[31:0] : prod_l[39:8];
      add_r <= (cmd_q == CMD_MIX8) ? prod_r[31:0] : prod_r[39:8];
    end
  end

  // emit path
  assign ring_lg   = (ring_size_log2 > 5'd16) ? 5'd16 : ring_size_log2;
  assign mask_full = (17'd1 << ring_lg) - 17'd1;
  assign emit_base = stereo_out ? {frame_q[14:0], 1'b0} : frame_q[15:0];
  assign emit_acc  = !ok_q ? 32'd0 : (ctrl.emit_right ? rd_r : rd_l);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_load) begin
      out_sample  <= emit_value(emit_acc, output_8bit);
      out_address <= (emit_base | {15'b0, ctrl.emit_right}) & mask_full[15:0];
      last        <= ctrl.emit_last;
    end
  end

  assign status.cmd      = cmd_q;
  assign status.stereo   = stereo_out;
  assign status.out_free = !out_valid || !out_stall;

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.emit_load))
    else $error("output valid without an emit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while held");

  a_write_sel_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_en |-> !ctrl.capture)
    else $error("store write while a new item is taken");

endmodule
